[src/sjf_pkg.sv]
// Shared constants and controller/datapath types for the shortest-job-first scheduler.
`timescale 1ns / 1ps

package sjf_pkg;

   // Capacity and field widths.
   localparam int MAX_PROCS  = 16;
   localparam int BURST_BITS = 16;
   localparam int IDX_W      = $clog2(MAX_PROCS);
   localparam int CNT_W      = $clog2(MAX_PROCS + 1);
   localparam int ID_W       = 4;
   localparam int IN_BURST_W = 16;
   localparam int OUT_BURST_W = 16;
   localparam int TIME_W     = 20;
   localparam int WSUM_W     = 24;
   localparam int TSUM_W     = 25;
   localparam int FRAC_W     = 8;
   localparam int AVG_W      = 28;
   localparam int DIV_W      = TSUM_W + FRAC_W;
   localparam int DCNT_W     = $clog2(DIV_W);

   // Controller states.
   typedef enum logic [2:0] {
      ST_LOAD,
      ST_SUM,
      ST_DIV_INIT,
      ST_DIV_WAIT,
      ST_DIV_TURN,
      ST_EMIT
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic sum_step;
      logic div_init;
      logic init_turn;
      logic div_step;
      logic store_turn;
      logic emit_step;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic k_last;
      logic div_done;
      logic out_free;
   } status_type;

endpackage

[src/sjf_schedule_times_top.sv]
// Top level of the shortest-job-first scheduler: controller plus datapath.
//
//   Channel  Direction  Handshake         Payload
//   req      in         req_valid/stall   burst_time, batch_last
//   rsp      out        rsp_valid/stall   process_id .. run_last (8 fields)
//
// Each burst is inserted into a sorted row as it arrives.
// On the batch's last item the block sums the waiting and turnaround times,
// loads the divider, runs both averages in turn through the shared serial
// divider, then emits the results in sorted order. Reset is synchronous and
// clears all control state.
// req_stall is high from batch close until the last result is registered; a
// stalled result holds the output register and pauses the result sequence.
`timescale 1ns / 1ps

module sjf_schedule_times_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [sjf_pkg::IN_BURST_W-1:0]      req_burst_time,
   input  logic                                req_batch_last,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [sjf_pkg::ID_W-1:0]            rsp_process_id,
   output logic [sjf_pkg::OUT_BURST_W-1:0]     rsp_burst_out,
   output logic [sjf_pkg::TIME_W-1:0]          rsp_waiting_time,
   output logic [sjf_pkg::TIME_W-1:0]          rsp_turnaround_time,
   output logic [sjf_pkg::AVG_W-1:0]           rsp_avg_waiting_fx,
   output logic [sjf_pkg::AVG_W-1:0]           rsp_avg_turnaround_fx,
   output logic                                rsp_overflow,
   output logic                                rsp_run_last
);
   import sjf_pkg::*;

   cmd_type    cmd;
   status_type status;

   // Sequencing.
   sjf_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_batch_last (req_batch_last),
      .req_stall      (req_stall),
      .status         (status),
      .cmd            (cmd)
   );

   // Storage and arithmetic.
   sjf_datapath u_datapath (
      .clock                 (clock),
      .reset                 (reset),
      .cmd                   (cmd),
      .status                (status),
      .req_burst_time        (req_burst_time),
      .rsp_stall             (rsp_stall),
      .rsp_valid             (rsp_valid),
      .rsp_process_id        (rsp_process_id),
      .rsp_burst_out         (rsp_burst_out),
      .rsp_waiting_time      (rsp_waiting_time),
      .rsp_turnaround_time   (rsp_turnaround_time),
      .rsp_avg_waiting_fx    (rsp_avg_waiting_fx),
      .rsp_avg_turnaround_fx (rsp_avg_turnaround_fx),
      .rsp_overflow          (rsp_overflow),
      .rsp_run_last          (rsp_run_last)
   );

endmodule

[src/sjf_ctrl.sv]
// Controller state machine that sequences loading, summing, dividing and result output.
`timescale 1ns / 1ps

module sjf_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_batch_last,
   output logic               req_stall,
   input  sjf_pkg::status_type status,
   output sjf_pkg::cmd_type    cmd
);
   import sjf_pkg::*;

   state_type state_ff;
   state_type state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_LOAD: begin
            if (req_valid && req_batch_last) state_in = ST_SUM;
         end
         ST_SUM: begin
            if (status.k_last) state_in = ST_DIV_INIT;
         end
         ST_DIV_INIT: begin
            state_in = ST_DIV_WAIT;
         end
         ST_DIV_WAIT: begin
            if (status.div_done) state_in = ST_DIV_TURN;
         end
         ST_DIV_TURN: begin
            if (status.div_done) state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (status.out_free && status.k_last) state_in = ST_LOAD;
         end
         default: state_in = ST_LOAD;
      endcase
   end

   // Outputs.
   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         ST_LOAD: begin
            req_stall = 1'b0;
            cmd.load  = req_valid;
         end
         ST_SUM: begin
            cmd.sum_step = 1'b1;
         end
         ST_DIV_INIT: begin
            // The waiting sum is complete only once the summing pass has ended.
            cmd.div_init = 1'b1;
         end
         ST_DIV_WAIT: begin
            cmd.div_step  = 1'b1;
            cmd.div_init  = status.div_done;
            cmd.init_turn = 1'b1;
         end
         ST_DIV_TURN: begin
            cmd.div_step   = 1'b1;
            cmd.store_turn = 1'b1;
         end
         ST_EMIT: begin
            cmd.emit_step = status.out_free;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

endmodule

[src/sjf_datapath.sv]
// Datapath: sorted insertion row, time accumulators, serial divider and output register.
`timescale 1ns / 1ps

module sjf_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  sjf_pkg::cmd_type                    cmd,
   output sjf_pkg::status_type                 status,
   input  logic [sjf_pkg::IN_BURST_W-1:0]      req_burst_time,
   input  logic                                rsp_stall,
   output logic                                rsp_valid,
   output logic [sjf_pkg::ID_W-1:0]            rsp_process_id,
   output logic [sjf_pkg::OUT_BURST_W-1:0]     rsp_burst_out,
   output logic [sjf_pkg::TIME_W-1:0]          rsp_waiting_time,
   output logic [sjf_pkg::TIME_W-1:0]          rsp_turnaround_time,
   output logic [sjf_pkg::AVG_W-1:0]           rsp_avg_waiting_fx,
   output logic [sjf_pkg::AVG_W-1:0]           rsp_avg_turnaround_fx,
   output logic                                rsp_overflow,
   output logic                                rsp_run_last
);
   import sjf_pkg::*;

   logic [BURST_BITS-1:0] burst_ff [MAX_PROCS];
   logic [ID_W-1:0]       id_ff    [MAX_PROCS];
   logic [CNT_W-1:0]      count_ff;
   logic                  ovf_ff;
   logic [IDX_W-1:0]      k_ff;
   logic [TIME_W-1:0]     elapsed_ff;
   logic [WSUM_W-1:0]     wsum_ff;
   logic [TSUM_W-1:0]     tsum_ff;
   logic [AVG_W-1:0]      avg_w_ff;
   logic [AVG_W-1:0]      avg_t_ff;
   logic [DIV_W-1:0]      dq_ff;
   logic [CNT_W-1:0]      rem_ff;
   logic [DCNT_W-1:0]     dcnt_ff;
   logic                  rsp_valid_ff;

   logic [BURST_BITS-1:0] new_burst;
   logic [MAX_PROCS-1:0]  lt;
   logic                  full;
   logic [BURST_BITS-1:0] k_burst;
   logic [TIME_W-1:0]     elapsed_in;
   logic [CNT_W:0]        trial;
   logic                  qbit;
   logic [CNT_W-1:0]      rem_in;
   logic [DIV_W-1:0]      dq_in;

   assign new_burst = req_burst_time[BURST_BITS-1:0];
   assign full      = (count_ff == CNT_W'(MAX_PROCS));
   assign k_burst   = burst_ff[k_ff];
   assign elapsed_in = elapsed_ff + TIME_W'(k_burst);

   assign status.k_last   = ({1'b0, k_ff} == (count_ff - CNT_W'(1)));
   assign status.div_done = (dcnt_ff == DCNT_W'(DIV_W - 1));
   assign status.out_free = !rsp_valid_ff || !rsp_stall;

   // Which valid entries hold a strictly larger burst than the incoming one.
   always_comb begin
      for (int i = 0; i < MAX_PROCS; i++) begin
         lt[i] = (CNT_W'(i) < count_ff) && (new_burst < burst_ff[i]);
      end
   end

   // Insertion row: larger entries shift up one place and the new burst drops in.
   always_ff @(posedge clock) begin
      if (cmd.load && !full) begin
         for (int i = 0; i < MAX_PROCS; i++) begin
            if (i > 0 && lt[(i > 0) ? i - 1 : 0]) begin
               burst_ff[i] <= burst_ff[(i > 0) ? i - 1 : 0];
               id_ff[i]    <= id_ff[(i > 0) ? i - 1 : 0];
            end else if (lt[i] || CNT_W'(i) == count_ff) begin
               burst_ff[i] <= new_burst;
               id_ff[i]    <= ID_W'(count_ff);
            end
         end
      end
   end

   // Serial restoring divide step: one quotient bit a cycle.
   always_comb begin
      trial  = {1'b0, rem_ff[CNT_W-2:0], dq_ff[DIV_W-1]} - {1'b0, count_ff};
      qbit   = !trial[CNT_W];
      rem_in = qbit ? trial[CNT_W-1:0] : {rem_ff[CNT_W-2:0], dq_ff[DIV_W-1]};
      dq_in  = {dq_ff[DIV_W-2:0], qbit};
   end

   // Batch control state, accumulators and divider.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         ovf_ff     <= 1'b0;
         k_ff       <= '0;
         elapsed_ff <= '0;
         wsum_ff    <= '0;
         tsum_ff    <= '0;
         dcnt_ff    <= '0;
      end else begin
         if (cmd.load) begin
            if (full) ovf_ff <= 1'b1;
            else      count_ff <= count_ff + CNT_W'(1);
         end
         if (cmd.sum_step) begin
            wsum_ff <= wsum_ff + WSUM_W'(elapsed_ff);
            tsum_ff <= tsum_ff + TSUM_W'(elapsed_in);
            if (status.k_last) begin
               k_ff       <= '0;
               elapsed_ff <= '0;
            end else begin
               k_ff       <= k_ff + IDX_W'(1);
               elapsed_ff <= elapsed_in;
            end
         end
         if (cmd.div_step) begin
            dcnt_ff <= status.div_done ? '0 : dcnt_ff + DCNT_W'(1);
         end
         if (cmd.emit_step) begin
            if (status.k_last) begin
               k_ff       <= '0;
               elapsed_ff <= '0;
               count_ff   <= '0;
               ovf_ff     <= 1'b0;
               wsum_ff    <= '0;
               tsum_ff    <= '0;
            end else begin
               k_ff       <= k_ff + IDX_W'(1);
               elapsed_ff <= elapsed_in;
            end
         end
      end
   end

   // Divider operands and stored averages.
   always_ff @(posedge clock) begin
      if (cmd.div_init) begin
         rem_ff <= '0;
         if (cmd.init_turn) dq_ff <= {tsum_ff, {FRAC_W{1'b0}}};
         else               dq_ff <= DIV_W'({wsum_ff, {FRAC_W{1'b0}}});
      end else if (cmd.div_step) begin
         dq_ff  <= dq_in;
         rem_ff <= rem_in;
      end
      if (cmd.div_step && status.div_done) begin
         if (cmd.store_turn) avg_t_ff <= dq_in[AVG_W-1:0];
         else                avg_w_ff <= dq_in[AVG_W-1:0];
      end
   end

   // Output valid flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit_step) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // Output payload register, loaded only when the previous result has transferred.
   always_ff @(posedge clock) begin
      if (cmd.emit_step) begin
         rsp_process_id        <= id_ff[k_ff];
         rsp_burst_out         <= OUT_BURST_W'(k_burst);
         rsp_waiting_time      <= elapsed_ff;
         rsp_turnaround_time   <= elapsed_in;
         rsp_avg_waiting_fx    <= avg_w_ff;
         rsp_avg_turnaround_fx <= avg_t_ff;
         rsp_overflow          <= ovf_ff;
         rsp_run_last          <= status.k_last;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule
